FILE: rtl/sser_pkg.sv
`timescale 1ns / 1ps

package sser_pkg;

    localparam int unsigned CharWidth    = 8;
    localparam int unsigned PayloadBytes = 7;
    localparam int unsigned PayloadWidth = PayloadBytes * CharWidth;
    localparam int unsigned LenWidth     = 3;
    localparam int unsigned KindWidth    = 3;
    localparam int unsigned CfgIdxWidth  = 3;
    localparam int unsigned OutDataWidth = 16;

    localparam logic [LenWidth-1:0] MaxPayload = LenWidth'(PayloadBytes);

    localparam logic [CharWidth-1:0] IdleChar     = 8'h00;
    localparam logic [CharWidth-1:0] SyncReset    = 8'h16;
    localparam logic [CharWidth-1:0] StxReset     = 8'h02;
    localparam logic [CharWidth-1:0] EtxReset     = 8'h03;
    localparam logic [CharWidth-1:0] CancelReset  = 8'h18;
    localparam logic [CharWidth-1:0] HeaderReset  = 8'h28;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_SYNC    = 3'd0,
        CFG_STX     = 3'd1,
        CFG_ETX     = 3'd2,
        CFG_CANCEL  = 3'd3,
        CFG_HEADER  = 3'd4,
        CFG_PAYLOAD = 3'd5
    } t_cfg_idx;

    typedef enum logic [KindWidth-1:0] {
        EV_NONE    = 3'd0,
        EV_HEADER  = 3'd1,
        EV_DATA    = 3'd2,
        EV_END     = 3'd3,
        EV_DISCARD = 3'd4,
        EV_ERROR   = 3'd5
    } t_event;

    typedef struct packed {
        logic [CharWidth-1:0]    sync_char;
        logic [CharWidth-1:0]    start_text_char;
        logic [CharWidth-1:0]    end_text_char;
        logic [CharWidth-1:0]    cancel_char;
        logic [CharWidth-1:0]    own_header;
        logic [PayloadWidth-1:0] own_payload;
    } t_cfg;

    typedef struct packed {
        logic                 line_busy;
        logic                 own_frame;
        logic [CharWidth-1:0] out_byte;
        t_event               event_kind;
    } t_result;

endpackage

FILE: rtl/sync_stx_etx_frame_receiver_top.sv
// Throughput: one character per cycle while the result side accepts, as the phase machine updates on each character.
// A character register and a result register decouple the two stream sides.
// Reset is synchronous and active low; it loads the default framing characters,
// clears our payload and puts the receiver into the search for the sync character.
`timescale 1ns / 1ps

module sync_stx_etx_frame_receiver_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Bits 7..0: rx_char.
    input  logic [sser_pkg::CharWidth-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Bits 2..0: event_kind, 10..3: out_byte, 11: own_frame, 12: line_busy, 15..13: zero.
    output logic [sser_pkg::OutDataWidth-1:0]  m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sser_pkg::CfgIdxWidth-1:0]   i_cfg_index,
    input  logic [sser_pkg::PayloadWidth-1:0]  i_cfg_data
);
    import sser_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;

    assign o_cfg_ready = 1'b1;

    sser_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    sser_deframer u_deframer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_s_char   (s_axis_tdata),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_result (w_result)
    );

    assign m_axis_tdata = {{(OutDataWidth - $bits(t_result)){1'b0}}, w_result};

endmodule

FILE: rtl/sser_cfg_regs.sv
`timescale 1ns / 1ps

module sser_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [sser_pkg::CfgIdxWidth-1:0] i_cfg_index,
    input  logic [sser_pkg::PayloadWidth-1:0] i_cfg_data,
    output sser_pkg::t_cfg                   o_cfg
);
    import sser_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC:    n_cfg.sync_char       = i_cfg_data[CharWidth-1:0];
                CFG_STX:     n_cfg.start_text_char = i_cfg_data[CharWidth-1:0];
                CFG_ETX:     n_cfg.end_text_char   = i_cfg_data[CharWidth-1:0];
                CFG_CANCEL:  n_cfg.cancel_char     = i_cfg_data[CharWidth-1:0];
                CFG_HEADER:  n_cfg.own_header      = i_cfg_data[CharWidth-1:0];
                CFG_PAYLOAD: n_cfg.own_payload     = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_char       <= SyncReset;
            r_cfg.start_text_char <= StxReset;
            r_cfg.end_text_char   <= EtxReset;
            r_cfg.cancel_char     <= CancelReset;
            r_cfg.own_header      <= HeaderReset;
            r_cfg.own_payload     <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/sser_deframer.sv
`timescale 1ns / 1ps

module sser_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sser_pkg::t_cfg                 i_cfg,
    input  logic                           i_s_valid,
    output logic                           o_s_ready,
    input  logic [sser_pkg::CharWidth-1:0] i_s_char,
    output logic                           o_m_valid,
    input  logic                           i_m_ready,
    output sser_pkg::t_result              o_m_result
);
    import sser_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SYNC = 3'd1,
        PH_STX  = 3'd2,
        PH_HDR  = 3'd3,
        PH_DATA = 3'd4,
        PH_ETX  = 3'd5
    } t_phase;

    logic                 r_in_valid;
    logic [CharWidth-1:0] r_in_char;
    logic                 r_out_valid;
    t_result              r_out;

    t_phase               r_phase;
    t_phase               n_phase;
    logic [LenWidth-1:0]  r_len;
    logic [LenWidth-1:0]  n_len;
    logic [LenWidth-1:0]  r_idx;
    logic [LenWidth-1:0]  n_idx;
    logic                 r_own;
    logic                 n_own;
    logic                 r_busy;
    logic                 n_busy;
    t_result              n_out;

    logic                 w_advance;
    logic [LenWidth-1:0]  w_hdr_len;
    logic [CharWidth-1:0] w_want;
    logic                 w_ok;
    logic [PayloadWidth+CharWidth-1:0] w_payload_ext;

    assign w_advance = r_in_valid && (!r_out_valid || i_m_ready);
    assign o_s_ready = !r_in_valid || w_advance;

    assign w_payload_ext = {{CharWidth{1'b0}}, i_cfg.own_payload};
    assign w_want        = w_payload_ext[r_idx*CharWidth +: CharWidth];
    assign w_hdr_len     = (r_in_char[LenWidth-1:0] > MaxPayload) ?
                           MaxPayload : r_in_char[LenWidth-1:0];
    assign w_ok          = r_own ? (r_in_char == w_want) : (r_in_char != i_cfg.cancel_char);

    always_comb begin
        n_phase          = r_phase;
        n_len            = r_len;
        n_idx            = r_idx;
        n_own            = r_own;
        n_busy           = r_busy;
        n_out.event_kind = EV_NONE;
        n_out.out_byte   = '0;
        n_out.own_frame  = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (r_in_char == IdleChar) begin
                    n_busy  = 1'b0;
                    n_phase = PH_SYNC;
                end
            end
            PH_STX: begin
                n_phase = (r_in_char == i_cfg.start_text_char) ? PH_HDR : PH_IDLE;
            end
            PH_HDR: begin
                if (r_in_char == i_cfg.cancel_char) begin
                    n_out.event_kind = EV_DISCARD;
                    n_phase          = PH_IDLE;
                end else begin
                    n_own            = (r_in_char == i_cfg.own_header);
                    n_len            = w_hdr_len;
                    n_idx            = '0;
                    n_out.event_kind = EV_HEADER;
                    n_out.out_byte   = r_in_char;
                    n_out.own_frame  = n_own;
                    n_phase          = (w_hdr_len == '0) ? PH_ETX : PH_DATA;
                end
            end
            PH_DATA: begin
                n_out.own_frame = r_own;
                if (w_ok) begin
                    n_out.event_kind = EV_DATA;
                    n_out.out_byte   = r_in_char;
                    n_idx            = r_idx + 1'b1;
                    if (n_idx >= r_len) begin
                        n_phase = PH_ETX;
                    end
                end else begin
                    n_out.event_kind = EV_DISCARD;
                    n_phase          = PH_IDLE;
                end
            end
            PH_ETX: begin
                n_out.own_frame = r_own;
                if (r_in_char == i_cfg.end_text_char) begin
                    n_out.event_kind = EV_END;
                    n_busy           = 1'b0;
                    n_phase          = PH_SYNC;
                end else begin
                    n_out.event_kind = EV_ERROR;
                    n_phase          = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_SYNC;
                if (r_in_char == i_cfg.sync_char) begin
                    n_busy  = 1'b1;
                    n_phase = PH_STX;
                end
            end
        endcase
        n_out.line_busy = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_SYNC;
            r_len       <= '0;
            r_idx       <= '0;
            r_own       <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            if (o_s_ready) begin
                r_in_valid <= i_s_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_len       <= n_len;
                r_idx       <= n_idx;
                r_own       <= n_own;
                r_busy      <= n_busy;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_ready && i_s_valid) begin
            r_in_char <= i_s_char;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_valid  = r_out_valid;
    assign o_m_result = r_out;

endmodule
